>>> rtl/core/sdpm_pkg.sv
// Shared types and constants for the subband dot-product mirror core.
`default_nettype none

package sdpm_pkg;

  // Input item action codes
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  // What kind of result pair an event produces
  typedef enum logic [1:0] {
    EV_FIRST  = 2'd0,
    EV_SECOND = 2'd1,
    EV_FINISH = 2'd2
  } ev_kind_e;

  localparam int SampleW  = 24;
  localparam int BlockW   = 5;
  localparam int TapW     = 5;
  localparam int TotalW   = 30;
  localparam int AccW     = 48;
  localparam int ProdW    = 37;   // 48-bit product after dropping 11 bits
  localparam int ResultW  = 32;
  localparam int PosW     = 6;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  // Queue between front and back; depth is a power of two
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef struct packed {
    ev_kind_e                  kind;
    logic [BlockW-1:0]         idx;    // block, or offset within the second group
    logic signed [AccW-1:0]    value;  // accumulator, or coefficient sum for finish
  } event_t;

endpackage

`default_nettype wire

>>> rtl/core/sdpm_front.sv
// Front end: accept, classify, coefficient store, multiply and accumulate.
`default_nettype none

module sdpm_front #(
  parameter int TAPS          = 32,
  parameter int FIRST_BLOCKS  = 16,
  parameter int SECOND_BLOCKS = 15
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [sdpm_pkg::InDataW-1:0]    in_data_i,
  input  wire logic [sdpm_pkg::QCntW-1:0]      q_count_i,
  output logic                                 push_o,
  output sdpm_pkg::event_t                     push_event_o
);

  localparam int IdxW = $clog2(TAPS);
  localparam int CntW = sdpm_pkg::QCntW + 1;

  sdpm_pkg::act_e                        act;
  logic [sdpm_pkg::BlockW-1:0]           blk;
  logic [sdpm_pkg::TapW-1:0]             tap;
  logic signed [sdpm_pkg::SampleW-1:0]   smp;
  logic [6:0]                            tap_ext;
  logic [6:0]                            blk_ext;
  logic [IdxW-1:0]                       cidx;
  logic                                  tap_ok;
  logic                                  accept;
  logic [CntW-1:0]                       pending;

  logic signed [sdpm_pkg::SampleW-1:0]   coef_q [TAPS];
  logic signed [sdpm_pkg::TotalW-1:0]    total_q;
  logic signed [sdpm_pkg::SampleW-1:0]   coef_rd;

  sdpm_pkg::ev_kind_e                    kind_c;
  logic [sdpm_pkg::BlockW-1:0]           idx_c;
  logic                                  emit_c;

  // stage 1
  logic                                  s1_v_q;
  logic                                  s1_fin_q, s1_emit_q, s1_tap0_q;
  sdpm_pkg::ev_kind_e                    s1_kind_q;
  logic [sdpm_pkg::BlockW-1:0]           s1_idx_q;
  logic signed [sdpm_pkg::SampleW-1:0]   s1_coef_q, s1_smp_q;
  logic signed [sdpm_pkg::TotalW-1:0]    s1_tot_q;

  // stage 2
  logic                                  s2_v_q;
  logic                                  s2_fin_q, s2_emit_q, s2_tap0_q;
  sdpm_pkg::ev_kind_e                    s2_kind_q;
  logic [sdpm_pkg::BlockW-1:0]           s2_idx_q;
  logic signed [sdpm_pkg::ProdW-1:0]     s2_prod_q;
  logic signed [sdpm_pkg::TotalW-1:0]    s2_tot_q;

  logic signed [2*sdpm_pkg::SampleW-1:0] prod_full;
  logic signed [sdpm_pkg::AccW-1:0]      acc_q, acc_d;
  logic signed [sdpm_pkg::AccW:0]        acc_sum;
  logic signed [sdpm_pkg::AccW:0]        prod_ext;

  assign act     = sdpm_pkg::act_e'(in_data_i[1:0]);
  assign blk     = in_data_i[6:2];
  assign tap     = in_data_i[11:7];
  assign smp     = $signed(in_data_i[35:12]);
  assign tap_ext = {2'b00, tap};
  assign blk_ext = {2'b00, blk};
  assign cidx    = tap_ext[IdxW-1:0];
  assign tap_ok  = tap_ext < 7'(TAPS);
  assign coef_rd = coef_q[cidx];

  // Reserve a queue slot for every item still in the pipeline
  assign pending    = CntW'(q_count_i) + CntW'(s1_v_q) + CntW'(s2_v_q);
  assign in_ready_o = pending < CntW'(sdpm_pkg::QDepth);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    kind_c = sdpm_pkg::EV_FIRST;
    idx_c  = blk;
    emit_c = 1'b0;
    if (act == sdpm_pkg::ACT_FINISH) begin
      kind_c = sdpm_pkg::EV_FINISH;
      emit_c = 1'b1;
    end else if (blk_ext < 7'(FIRST_BLOCKS)) begin
      emit_c = tap_ext == 7'(TAPS - 1);
    end else if (blk_ext < 7'(FIRST_BLOCKS + SECOND_BLOCKS)) begin
      kind_c = sdpm_pkg::EV_SECOND;
      idx_c  = sdpm_pkg::BlockW'(blk_ext - 7'(FIRST_BLOCKS));
      emit_c = tap_ext == 7'(TAPS - 1);
    end
  end

  // Coefficient store and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) coef_q[i] <= '0;
      total_q <= '0;
    end else if (accept && act == sdpm_pkg::ACT_LOAD && tap_ok) begin
      coef_q[cidx] <= smp;
      total_q      <= total_q - {{6{coef_rd[23]}}, coef_rd} + {{6{smp[23]}}, smp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept && ((act == sdpm_pkg::ACT_SAMPLE && tap_ok) ||
                           act == sdpm_pkg::ACT_FINISH);
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fin_q  <= act == sdpm_pkg::ACT_FINISH;
    s1_emit_q <= emit_c;
    s1_tap0_q <= tap == '0;
    s1_kind_q <= kind_c;
    s1_idx_q  <= idx_c;
    s1_coef_q <= coef_rd;
    s1_smp_q  <= smp;
    s1_tot_q  <= total_q;
  end

  assign prod_full = s1_coef_q * s1_smp_q;

  always_ff @(posedge clk_i) begin
    s2_fin_q  <= s1_fin_q;
    s2_emit_q <= s1_emit_q;
    s2_tap0_q <= s1_tap0_q;
    s2_kind_q <= s1_kind_q;
    s2_idx_q  <= s1_idx_q;
    s2_prod_q <= prod_full[2*sdpm_pkg::SampleW-1:11];
    s2_tot_q  <= s1_tot_q;
  end

  // Accumulate with saturation; tap zero restarts the sum
  assign prod_ext = {{12{s2_prod_q[36]}}, s2_prod_q};

  always_comb begin
    acc_sum = s2_tap0_q ? prod_ext : ({acc_q[47], acc_q} + prod_ext);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_d = acc_sum[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      acc_d = acc_sum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s2_v_q && !s2_fin_q) begin
      acc_q <= acc_d;
    end
  end

  assign push_o             = s2_v_q && s2_emit_q;
  assign push_event_o.kind  = s2_kind_q;
  assign push_event_o.idx   = s2_idx_q;
  assign push_event_o.value = s2_fin_q ? {{18{s2_tot_q[29]}}, s2_tot_q} : acc_d;

endmodule

`default_nettype wire

>>> rtl/core/sdpm_queue.sv
// Short event queue between the front end and the output back end.
`default_nettype none

module sdpm_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire sdpm_pkg::event_t             push_event_i,
  input  wire logic                         pop_i,
  output logic                              valid_o,
  output sdpm_pkg::event_t                  head_o,
  output logic [sdpm_pkg::QCntW-1:0]        count_o
);

  sdpm_pkg::event_t                 mem_q [sdpm_pkg::QDepth];
  logic [sdpm_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [sdpm_pkg::QCntW-1:0]       cnt_q;
  logic                             do_pop;

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_event_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + sdpm_pkg::QCntW'(push_i) - sdpm_pkg::QCntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sdpm_back.sv
// Back end: round, saturate and mirror each event into a pair of result items.
`default_nettype none

module sdpm_back #(
  parameter int FIRST_BLOCKS  = 16,
  parameter int SECOND_BLOCKS = 15
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_valid_i,
  input  wire sdpm_pkg::event_t                     q_event_i,
  output logic                                      pop_o,
  input  wire logic signed [sdpm_pkg::ResultW-1:0]  window_constant_i,
  output logic                                      m_valid_o,
  input  wire logic                                 m_ready_i,
  output logic [sdpm_pkg::OutDataW-1:0]             m_data_o,
  output logic                                      m_last_o
);

  localparam logic [6:0] PosF    = 7'(FIRST_BLOCKS);
  localparam logic [6:0] Pos2F   = 7'(2 * FIRST_BLOCKS);
  localparam logic [6:0] Pos2F1  = 7'(2 * FIRST_BLOCKS + 1);
  localparam logic [6:0] PosTop  = 7'(2 * FIRST_BLOCKS + 2 * SECOND_BLOCKS + 1);
  localparam logic [6:0] PosFin1 = 7'(2 * FIRST_BLOCKS + 1 + SECOND_BLOCKS);

  localparam logic signed [31:0] ResMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ResMin = 32'sh8000_0000;

  logic signed [sdpm_pkg::AccW:0]      rnd_sum;
  logic signed [sdpm_pkg::ProdW-1:0]   rnd_sh;
  logic signed [31:0]                  rnd;
  logic [6:0]                          idx_ext;
  logic signed [31:0]                  r0_c, v1_c;
  logic                                neg_c;
  logic [6:0]                          pos0_c, pos1_c;

  logic                                w_v_q, w_phase_q, w_neg_q;
  logic signed [31:0]                  w_r0_q, w_v1_q;
  logic [sdpm_pkg::PosW-1:0]           w_pos0_q, w_pos1_q;
  logic signed [31:0]                  neg_r0;

  logic                                o_v_q, o_last_q;
  logic [sdpm_pkg::PosW-1:0]           o_pos_q;
  logic signed [31:0]                  o_res_q;

  logic                                out_free, out_load, w_free;

  // Round half up by 12 bits, then clamp to 32 bits
  assign rnd_sum = {q_event_i.value[47], q_event_i.value} + 49'sd2048;
  assign rnd_sh  = rnd_sum[48:12];

  always_comb begin
    if (rnd_sh[36:31] == {6{rnd_sh[36]}}) begin
      rnd = rnd_sh[31:0];
    end else begin
      rnd = rnd_sh[36] ? ResMin : ResMax;
    end
  end

  assign idx_ext = {2'b00, q_event_i.idx};

  always_comb begin
    r0_c   = rnd;
    v1_c   = rnd;
    neg_c  = 1'b0;
    pos0_c = idx_ext;
    pos1_c = Pos2F - idx_ext;
    case (q_event_i.kind)
      sdpm_pkg::EV_FIRST: begin
        neg_c = 1'b1;
      end
      sdpm_pkg::EV_SECOND: begin
        pos0_c = Pos2F1 + idx_ext;
        pos1_c = PosTop - idx_ext;
      end
      sdpm_pkg::EV_FINISH: begin
        r0_c   = window_constant_i;
        v1_c   = -$signed(q_event_i.value[31:0]);
        pos0_c = PosF;
        pos1_c = PosFin1;
      end
      default: begin
        neg_c = 1'b0;
      end
    endcase
  end

  assign out_free = !o_v_q || m_ready_i;
  assign out_load = w_v_q && out_free;
  assign w_free   = !w_v_q || (out_load && w_phase_q);
  assign pop_o    = q_valid_i && w_free;

  assign neg_r0 = (w_r0_q == ResMin) ? ResMax : -w_r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q     <= 1'b0;
      w_phase_q <= 1'b0;
      o_v_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        w_v_q     <= 1'b1;
        w_phase_q <= 1'b0;
      end else if (out_load) begin
        w_v_q     <= !w_phase_q;
        w_phase_q <= 1'b1;
      end
      if (out_free) o_v_q <= w_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      w_r0_q   <= r0_c;
      w_v1_q   <= v1_c;
      w_neg_q  <= neg_c;
      w_pos0_q <= pos0_c[5:0];
      w_pos1_q <= pos1_c[5:0];
    end
    if (out_load) begin
      o_pos_q  <= w_phase_q ? w_pos1_q : w_pos0_q;
      o_res_q  <= !w_phase_q ? w_r0_q : (w_neg_q ? neg_r0 : w_v1_q);
      o_last_q <= w_phase_q;
    end
  end

  assign m_valid_o = o_v_q;
  assign m_data_o  = {2'b00, o_res_q, o_pos_q};
  assign m_last_o  = o_last_q;

endmodule

`default_nettype wire

>>> rtl/core/subband_dot_product_mirror_core.sv
// Top level of the subband dot-product mirror core.
//
// Input stream (s_axis): one item per handshake carrying action, block, tap
// and sample. Load items write one coefficient; sample items are multiplied
// by the stored coefficient of their tap and summed in a 48-bit accumulator;
// finish items ask for the closing pair. A steady stream of load, sample and
// finish items is taken at one item per cycle while s_axis_tready is high.
// Output stream (m_axis): each block's last tap and each finish item give two
// items, the second marked by tlast. A pair passes the two front-end stages,
// the event queue and the back end's hold and output registers; the second
// item follows in the cycle after the first is taken. The queue hands on the
// next event only when the hold register frees; items behind wait for room.
// A four-entry event queue sits between the multiply-accumulate front end and
// the output stage: when the receiver stalls, s_axis keeps taking items until
// the queue and the two pipeline stages in front of it are spoken for.
// Reset clears the coefficients, their sum, the accumulator, the window
// constant and all valid flags. cfg_we_i writes the window constant.
`default_nettype none

module subband_dot_product_mirror_core #(
  parameter int TAPS          = 32,
  parameter int FIRST_BLOCKS  = 16,
  parameter int SECOND_BLOCKS = 15
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [sdpm_pkg::ResultW-1:0]       cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [1:0] action, [6:2] block, [11:7] tap, [35:12] sample, [39:36] zero
  input  wire logic [sdpm_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [5:0] position, [37:6] result, [39:38] zero
  output logic [sdpm_pkg::OutDataW-1:0]           m_axis_tdata,
  output logic                                    m_axis_tlast
);

  logic signed [sdpm_pkg::ResultW-1:0]  window_constant_q;
  logic                                 push;
  sdpm_pkg::event_t                     push_event;
  logic                                 pop;
  logic                                 q_valid;
  sdpm_pkg::event_t                     q_head;
  logic [sdpm_pkg::QCntW-1:0]           q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_constant_q <= '0;
    end else if (cfg_we_i) begin
      window_constant_q <= $signed(cfg_wdata_i);
    end
  end

  sdpm_front #(
    .TAPS          (TAPS),
    .FIRST_BLOCKS  (FIRST_BLOCKS),
    .SECOND_BLOCKS (SECOND_BLOCKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_event_o (push_event)
  );

  sdpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_event_i (push_event),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head),
    .count_o      (q_count)
  );

  sdpm_back #(
    .FIRST_BLOCKS  (FIRST_BLOCKS),
    .SECOND_BLOCKS (SECOND_BLOCKS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_event_i         (q_head),
    .pop_o             (pop),
    .window_constant_i (window_constant_q),
    .m_valid_o         (m_axis_tvalid),
    .m_ready_i         (m_axis_tready),
    .m_data_o          (m_axis_tdata),
    .m_last_o          (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/core/sdpm_checker.sv
// Port-level checks for the subband dot-product mirror core, bound to the top.
`default_nettype none

module sdpm_checker #(
  parameter int FIRST_BLOCKS  = 16,
  parameter int SECOND_BLOCKS = 15
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [sdpm_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic                              m_axis_tlast
);

  localparam logic [5:0] FinPos0  = 6'(FIRST_BLOCKS);
  localparam logic [5:0] FinPos1  = 6'(2 * FIRST_BLOCKS + 1 + SECOND_BLOCKS);
  localparam logic       NoAlias  = (FIRST_BLOCKS + SECOND_BLOCKS) < 63;

  logic m_take;
  assign m_take = m_axis_tvalid && m_axis_tready;

  // Hold a stalled item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // The second item of a pair follows straight after the first
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_take && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second item of a pair not ready after the first");

  // A finish pair lands on its two fixed positions
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NoAlias && m_take && !m_axis_tlast && m_axis_tdata[5:0] == FinPos0 |=>
      m_axis_tdata[5:0] == FinPos1)
    else $error("finish pair at wrong positions");

endmodule

bind subband_dot_product_mirror_core sdpm_checker #(
  .FIRST_BLOCKS  (FIRST_BLOCKS),
  .SECOND_BLOCKS (SECOND_BLOCKS)
) u_sdpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
